[hdl/msv_pkg.sv]
// ---------------------------------------------------------------------------
// msv_pkg
// Shared types, constants and SHA-256 helpers of the share validator.
// ---------------------------------------------------------------------------
package msv_pkg;

	// result status codes
	localparam logic [2:0] ST_STORED  = 3'd0;
	localparam logic [2:0] ST_ACCEPT  = 3'd1;
	localparam logic [2:0] ST_NOJOB   = 3'd2;
	localparam logic [2:0] ST_STALE   = 3'd3;
	localparam logic [2:0] ST_LOWDIFF = 3'd4;

	// job word indexes
	localparam int unsigned JOB_WORDS = 10;
	localparam logic [3:0] WIDX_VERSION = 4'd8;
	localparam logic [3:0] WIDX_JOBID   = 4'd9;

	localparam logic [63:0] TARGET_RESET = 64'h0000_0000_FFFF_0000;

	localparam int unsigned HDR_BITS  = 640;
	localparam int unsigned HASH_BITS = 256;
	localparam int unsigned BLK_BITS  = 512;

	localparam logic [63:0] LEN_HDR = 64'd640;
	localparam logic [63:0] LEN_MID = 64'd256;

	localparam logic [255:0] SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// config register addresses, 8 bytes apart
	localparam logic ADDR_TARGET = 1'b0;
	localparam logic ADDR_ANY    = 1'b1;

	typedef enum logic [1:0] {
		K_LOAD,
		K_HASH,
		K_NOJOB,
		K_STALE
	} kind_t;

	// header is big-endian: version, prevhash, merkle, ntime, nbits, nonce
	typedef struct packed {
		kind_t                 kind;
		logic [HDR_BITS-1:0]   hdr;
		logic [31:0]           job_id;
	} entry_t;

	typedef struct packed {
		logic [63:0] target_word;
		logic        accept_any;
	} cfg_t;

	function automatic logic [31:0] ep0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] ep1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] sg0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sg1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bswap(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

[hdl/mining_share_validator_unit.sv]
// ---------------------------------------------------------------------------
// mining_share_validator_unit
// Double SHA-256 proof-of-work check of mining shares.
// ---------------------------------------------------------------------------
// Input stream s_*: s_tuser is op (0 load a job word, 1 submit a share).
// Every item gives exactly one item on m_*: status, share echo and counters.
// Loads and shares rejected for no job or stale job id pass through the queue
// and show their result from the output register. A share that is hashed
// runs three compressions in turn on one round unit; that unit sets the rate.
// The front stores job words and classifies items into a two-entry queue,
// so it keeps taking items while the back is hashing, until the queue fills.
// The result sits in an output register; the back takes the next queued
// item only once that register is free or being read, so a stalled receiver
// holds the block without losing anything.
// APB port: target_word at 0x0 (64 bits), accept_any at 0x8.
// Reset clears the job (no valid job), the counters and the registers to
// their defaults, and empties the queue.
// ---------------------------------------------------------------------------
module mining_share_validator_unit #(
	parameter int COUNTER_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// word_index, word_value, share_job_id, share_ntime, share_nonce,
	// share_version, version_given, zero fill
	input  logic [199:0] s_tdata,
	// op
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, out_job_id, out_nonce, out_ntime, out_version,
	// shares_seen, shares_accepted, shares_rejected, zero fill
	output logic [231:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	msv_pkg::cfg_t   cfg_q;
	msv_pkg::entry_t front_ent;
	msv_pkg::entry_t q_ent;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_word <= msv_pkg::TARGET_RESET;
			cfg_q.accept_any  <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3])
				msv_pkg::ADDR_TARGET: cfg_q.target_word <= pwdata;
				msv_pkg::ADDR_ANY:    cfg_q.accept_any  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			msv_pkg::ADDR_TARGET: prdata = cfg_q.target_word;
			msv_pkg::ADDR_ANY:    prdata = {63'd0, cfg_q.accept_any};
			default:              prdata = '0;
		endcase
	end

	msv_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_op            (s_tuser[0]),
		.in_word_index    (s_tdata[3:0]),
		.in_word_value    (s_tdata[67:4]),
		.in_job_id        (s_tdata[99:68]),
		.in_ntime         (s_tdata[131:100]),
		.in_nonce         (s_tdata[163:132]),
		.in_version       (s_tdata[195:164]),
		.in_version_given (s_tdata[196]),
		.q_full           (q_full),
		.in_ready         (s_tready),
		.push             (push),
		.ent              (front_ent)
	);

	msv_queue #(
		.WIDTH ($bits(msv_pkg::entry_t))
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_ent),
		.full   (q_full),
		.pop    (pop),
		.dout   (q_ent),
		.empty  (q_empty)
	);

	msv_back #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_ent     (q_ent),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

[hdl/msv_queue.sv]
// ---------------------------------------------------------------------------
// msv_queue
// Two-entry queue between the classifier and the hash engine.
// ---------------------------------------------------------------------------
module msv_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[hdl/msv_front.sv]
// ---------------------------------------------------------------------------
// msv_front
// Accepts items, keeps the job words and classifies each submit.
// ---------------------------------------------------------------------------
module msv_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_op,
	input  logic [3:0]      in_word_index,
	input  logic [63:0]     in_word_value,
	input  logic [31:0]     in_job_id,
	input  logic [31:0]     in_ntime,
	input  logic [31:0]     in_nonce,
	input  logic [31:0]     in_version,
	input  logic            in_version_given,
	input  logic            q_full,
	output logic            in_ready,
	output logic            push,
	output msv_pkg::entry_t ent
);

	logic [63:0] job_q [msv_pkg::JOB_WORDS];
	logic [31:0] version;
	logic [511:0] words;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	assign version = in_version_given ? in_version : job_q[msv_pkg::WIDX_VERSION][63:32];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			words[511 - 64*i -: 64] = job_q[i];
		end
	end

	always_comb begin
		ent.hdr    = {version, words, in_ntime, job_q[msv_pkg::WIDX_VERSION][31:0], in_nonce};
		ent.job_id = in_job_id;
		if (!in_op) begin
			ent.kind = msv_pkg::K_LOAD;
		end else if (!job_q[msv_pkg::WIDX_JOBID][32]) begin
			ent.kind = msv_pkg::K_NOJOB;
		end else if (in_job_id != job_q[msv_pkg::WIDX_JOBID][31:0]) begin
			ent.kind = msv_pkg::K_STALE;
		end else begin
			ent.kind = msv_pkg::K_HASH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < msv_pkg::JOB_WORDS; i++) begin
				job_q[i] <= '0;
			end
		end else if (push && !in_op) begin
			for (int i = 0; i < msv_pkg::JOB_WORDS; i++) begin
				if (in_word_index == 4'(i)) begin
					job_q[i] <= in_word_value;
				end
			end
		end
	end

endmodule

[hdl/msv_sha.sv]
// ---------------------------------------------------------------------------
// msv_sha
// One SHA-256 compression, one round per clock, final add after the last round.
// ---------------------------------------------------------------------------
module msv_sha (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [511:0] block,
	input  logic [255:0] hin,
	output logic         done,
	output logic [255:0] hout
);

	logic [31:0] st_q [8];
	logic [31:0] w_q [16];
	logic [31:0] hin_q [8];
	logic [6:0]  rnd_q;
	logic        busy_q;
	logic        done_q;
	logic [255:0] hout_q;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;

	assign done = done_q;
	assign hout = hout_q;

	always_comb begin
		t1 = st_q[7] + msv_pkg::ep1(st_q[4]) + ((st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6]))
			+ msv_pkg::SHA_K[rnd_q[5:0]] + w_q[0];
		t2 = msv_pkg::ep0(st_q[0])
			+ ((st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]));
		w_new = w_q[0] + msv_pkg::sg0(w_q[1]) + w_q[9] + msv_pkg::sg1(w_q[14]);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 8; i++) begin
				st_q[i]  <= hin[255 - 32*i -: 32];
				hin_q[i] <= hin[255 - 32*i -: 32];
			end
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= block[511 - 32*i -: 32];
			end
		end else if (busy_q && !rnd_q[6]) begin
			st_q[0] <= t1 + t2;
			st_q[1] <= st_q[0];
			st_q[2] <= st_q[1];
			st_q[3] <= st_q[2];
			st_q[4] <= st_q[3] + t1;
			st_q[5] <= st_q[4];
			st_q[6] <= st_q[5];
			st_q[7] <= st_q[6];
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
		if (busy_q && rnd_q[6]) begin
			for (int i = 0; i < 8; i++) begin
				hout_q[255 - 32*i -: 32] <= hin_q[i] + st_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				if (rnd_q[6]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					rnd_q <= rnd_q + 7'd1;
				end
			end
		end
	end

endmodule

[hdl/msv_back.sv]
// ---------------------------------------------------------------------------
// msv_back
// Runs the double hash, checks the target, keeps counters, holds the result.
// ---------------------------------------------------------------------------
module msv_back #(
	parameter int COUNTER_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  msv_pkg::cfg_t   cfg,
	input  logic            q_empty,
	input  msv_pkg::entry_t q_ent,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [231:0]    out_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_H1,
		S_H2,
		S_H3,
		S_CMP,
		S_OUT
	} state_t;

	state_t          state_q;
	msv_pkg::entry_t ent_q;
	logic            start_q;
	logic            pass_q;
	logic            ovalid_q;
	logic [231:0]    odata_q;
	logic [COUNTER_BITS-1:0] seen_q;
	logic [COUNTER_BITS-1:0] acc_q;
	logic [COUNTER_BITS-1:0] rej_q;

	logic            sha_done;
	logic [255:0]    sha_hout;
	logic [511:0]    blk;
	logic [255:0]    hin;
	logic            slot_free;
	logic            res_wr;
	logic [2:0]      res_status;
	msv_pkg::entry_t sel_ent;
	logic [63:0]     hi;

	assign slot_free = !ovalid_q || out_ready;
	assign pop       = (state_q == S_IDLE) && !q_empty && slot_free;
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;
	assign sel_ent   = (state_q == S_IDLE) ? q_ent : ent_q;

	// reversed digest, leading 64 bits
	assign hi = {msv_pkg::bswap(sha_hout[31:0]), msv_pkg::bswap(sha_hout[63:32])};

	always_comb begin
		unique case (state_q)
			S_H2: begin
				blk = {ent_q.hdr[127:0], 8'h80, 312'd0, msv_pkg::LEN_HDR};
				hin = sha_hout;
			end
			S_H3: begin
				blk = {sha_hout, 8'h80, 184'd0, msv_pkg::LEN_MID};
				hin = msv_pkg::SHA_IV;
			end
			default: begin
				blk = ent_q.hdr[639:128];
				hin = msv_pkg::SHA_IV;
			end
		endcase
	end

	always_comb begin
		res_wr     = 1'b0;
		res_status = msv_pkg::ST_STORED;
		if (pop) begin
			unique case (q_ent.kind)
				msv_pkg::K_LOAD: begin
					res_wr = 1'b1;
				end
				msv_pkg::K_NOJOB: begin
					res_wr     = 1'b1;
					res_status = msv_pkg::ST_NOJOB;
				end
				msv_pkg::K_STALE: begin
					res_wr     = 1'b1;
					res_status = msv_pkg::ST_STALE;
				end
				default: begin
					res_wr = 1'b0;
				end
			endcase
		end else if (state_q == S_OUT && slot_free) begin
			res_wr     = 1'b1;
			res_status = pass_q ? msv_pkg::ST_ACCEPT : msv_pkg::ST_LOWDIFF;
		end
	end

	msv_sha u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.block  (blk),
		.hin    (hin),
		.done   (sha_done),
		.hout   (sha_hout)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_ent;
		end
		if (state_q == S_H3 && sha_done) begin
			pass_q <= 1'b0;
		end
		if (state_q == S_CMP) begin
			pass_q <= cfg.accept_any || (hi < cfg.target_word)
				|| (hi == cfg.target_word && sha_hout[255:64] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			start_q  <= 1'b0;
			ovalid_q <= 1'b0;
			odata_q  <= '0;
			seen_q   <= '0;
			acc_q    <= '0;
			rej_q    <= '0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop && q_ent.kind == msv_pkg::K_HASH) begin
						state_q <= S_H1;
						start_q <= 1'b1;
					end
				end
				S_H1: begin
					if (sha_done) begin
						state_q <= S_H2;
						start_q <= 1'b1;
					end
				end
				S_H2: begin
					if (sha_done) begin
						state_q <= S_H3;
						start_q <= 1'b1;
					end
				end
				S_H3: begin
					if (sha_done) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (res_wr) begin
				ovalid_q <= 1'b1;
				if (res_status == msv_pkg::ST_STORED) begin
					odata_q <= {5'd0, 32'(rej_q), 32'(acc_q), 32'(seen_q), 128'd0,
						msv_pkg::ST_STORED};
				end else begin
					seen_q <= seen_q + 1'b1;
					if (res_status == msv_pkg::ST_ACCEPT) begin
						acc_q <= acc_q + 1'b1;
					end else begin
						rej_q <= rej_q + 1'b1;
					end
					odata_q <= {5'd0,
						(res_status == msv_pkg::ST_ACCEPT) ? 32'(rej_q) : 32'(rej_q + 1'b1),
						(res_status == msv_pkg::ST_ACCEPT) ? 32'(acc_q + 1'b1) : 32'(acc_q),
						32'(seen_q + 1'b1),
						sel_ent.hdr[639:608], sel_ent.hdr[95:64], sel_ent.hdr[31:0],
						sel_ent.job_id, res_status};
				end
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/msv_checker.sv]
// ---------------------------------------------------------------------------
// msv_checker
// Port-level checks of the share validator, bound to the top level.
// ---------------------------------------------------------------------------
module msv_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [231:0] m_tdata
);

	// a result held back by the receiver stays
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= msv_pkg::ST_LOWDIFF)
		else $error("bad status code");

	// a stored word echoes no share
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == msv_pkg::ST_STORED |-> m_tdata[130:3] == '0)
		else $error("load item carries share fields");

	// every counted share is either accepted or rejected
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[194:163] + m_tdata[226:195]) == m_tdata[162:131])
		else $error("counters disagree");

endmodule

bind mining_share_validator_unit msv_checker u_msv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[sim/mining_share_validator_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mining_share_validator_checker
// Watches the item streams and the register port of the share validator,
// predicts every result with its own double SHA-256 and job state, and
// compares each result field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module mining_share_validator_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [199:0] s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [231:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	input  logic         pready,
	output int           fail_count,
	output int           results_pending
);

	// last member sits in the lowest bits, as on m_tdata
	typedef struct packed {
		logic [31:0] rejected;
		logic [31:0] accepted;
		logic [31:0] seen;
		logic [31:0] version;
		logic [31:0] ntime;
		logic [31:0] nonce;
		logic [31:0] job_id;
		logic [2:0]  status;
	} share_result_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [255:0] HASH_START = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [63:0]   job_word [10];
	logic [63:0]   target;
	logic          any_share;
	logic [31:0]   share_total, accept_total, reject_total;
	share_result_t expected_results [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [255:0] compress(input logic [255:0] st, input logic [511:0] blk);
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
		for (int i = 16; i < 64; i++) begin
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
				+ (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		end
		for (int i = 0; i < 8; i++) v[i] = st[255 - 32*i -: 32];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) st[255 - 32*i -: 32] = st[255 - 32*i -: 32] + v[i];
		return st;
	endfunction

	// double sha-256 of the header, byte reversed, against the target
	function automatic logic meets_target(input logic [31:0] ver, input logic [31:0] ntime,
			input logic [31:0] nonce);
		logic [639:0] header;
		logic [255:0] mid, digest, reversed;
		header = {ver, job_word[0], job_word[1], job_word[2], job_word[3], job_word[4],
			job_word[5], job_word[6], job_word[7], ntime, job_word[8][31:0], nonce};
		mid = compress(HASH_START, header[639:128]);
		mid = compress(mid, {header[127:0], 8'h80, 312'd0, 64'd640});
		digest = compress(HASH_START, {mid, 8'h80, 184'd0, 64'd256});
		if (any_share) return 1'b1;
		for (int i = 0; i < 32; i++) reversed[255 - 8*i -: 8] = digest[8*i +: 8];
		return reversed <= {target, 192'd0};
	endfunction

	function automatic share_result_t predict_share(input logic is_submit, input logic [199:0] d);
		share_result_t r;
		logic [3:0] widx;
		logic [31:0] ver;
		r = '0;
		widx = d[3:0];
		if (!is_submit) begin
			if (widx < msv_pkg::JOB_WORDS) job_word[widx] = d[67:4];
		end else begin
			ver = d[196] ? d[195:164] : job_word[msv_pkg::WIDX_VERSION][63:32];
			share_total++;
			if (!job_word[msv_pkg::WIDX_JOBID][32]) r.status = msv_pkg::ST_NOJOB;
			else if (d[99:68] != job_word[msv_pkg::WIDX_JOBID][31:0])
				r.status = msv_pkg::ST_STALE;
			else if (meets_target(ver, d[131:100], d[163:132])) r.status = msv_pkg::ST_ACCEPT;
			else r.status = msv_pkg::ST_LOWDIFF;
			if (r.status == msv_pkg::ST_ACCEPT) accept_total++;
			else reject_total++;
			r.job_id = d[99:68];
			r.nonce = d[163:132];
			r.ntime = d[131:100];
			r.version = ver;
		end
		r.seen = share_total;
		r.accepted = accept_total;
		r.rejected = reject_total;
		return r;
	endfunction

	assign results_pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		share_result_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < 10; i++) job_word[i] = '0;
			target = msv_pkg::TARGET_RESET;
			any_share = 1'b0;
			share_total = '0;
			accept_total = '0;
			reject_total = '0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {msv_pkg::ADDR_TARGET, 3'b000}) target = pwdata;
				else if (paddr == {msv_pkg::ADDR_ANY, 3'b000}) any_share = pwdata[0];
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[226:0];
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected item, expected none, actual %h", $time, got);
				end else begin
					want = expected_results.pop_front();
					if (got.status != want.status || got.job_id != want.job_id
							|| got.nonce != want.nonce || got.ntime != want.ntime
							|| got.version != want.version || got.seen != want.seen
							|| got.accepted != want.accepted || got.rejected != want.rejected) begin
						fail_count++;
						$display("%0t: mismatch, expected st=%0d id=%h n=%h t=%h v=%h cnt=%0d/%0d/%0d",
							$time, want.status, want.job_id, want.nonce, want.ntime, want.version,
							want.seen, want.accepted, want.rejected);
						$display("%0t:           actual   st=%0d id=%h n=%h t=%h v=%h cnt=%0d/%0d/%0d",
							$time, got.status, got.job_id, got.nonce, got.ntime, got.version,
							got.seen, got.accepted, got.rejected);
					end
				end
			end
			if (s_tvalid && s_tready) expected_results.push_back(predict_share(s_tuser[0], s_tdata));
		end
	end

endmodule

[sim/mining_share_validator_unit_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mining_share_validator_unit_test
// Drives job loads and share submits into the share validator under random
// stalls on both sides and several target settings; the checker beside the
// block predicts and compares every result.
// ---------------------------------------------------------------------------
module mining_share_validator_unit_test;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SUBMIT = 1'b1;
	localparam logic [3:0] REG_TARGET = {msv_pkg::ADDR_TARGET, 3'b000};
	localparam logic [3:0] REG_ANY    = {msv_pkg::ADDR_ANY, 3'b000};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [199:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [231:0] m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [63:0]  pwdata = '0;
	logic [63:0]  prdata;
	logic         pready;
	int           fail_count;
	int           results_pending;

	int           send_idle_pct = 31;
	int           recv_idle_pct = 58;
	int           hold_request = 0;
	logic [31:0]  live_job_id;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	mining_share_validator_unit DUT (.*);

	mining_share_validator_checker share_checker (.*);

	// receiver: random stalls, plus one long hold while the sender keeps going
	always @(negedge clk) begin
		if (hold_request > 0) begin
			m_tready = 1'b0;
			hold_request--;
		end else begin
			m_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		#(64'd60_000_000);
		$display("tb: failure");
		$finish;
	end

	// called at a falling edge, returns at a falling edge after the item is taken
	task automatic push_item(input logic op, input logic [3:0] widx, input logic [63:0] wval,
			input logic [31:0] jid, input logic [31:0] ntime, input logic [31:0] nonce,
			input logic [31:0] ver, input logic vgiven);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {3'd0, vgiven, ver, nonce, ntime, jid, wval, widx};
		// ready only moves at rising edges, so it is settled here
		while (!s_tready) @(negedge clk);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic load_word(input logic [3:0] widx, input logic [63:0] wval);
		push_item(OP_LOAD, widx, wval, $urandom, $urandom, $urandom, $urandom,
			1'($urandom_range(1)));
	endtask

	task automatic submit_share(input logic [31:0] jid, input logic [31:0] ver, input logic vgiven);
		push_item(OP_SUBMIT, 4'($urandom), {$urandom, $urandom}, jid, $urandom, $urandom,
			ver, vgiven);
	endtask

	task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic drain_results();
		while (results_pending != 0) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	task automatic random_job(input logic valid);
		for (int w = 0; w < 9; w++) load_word(4'(w), {$urandom, $urandom});
		live_job_id = $urandom;
		load_word(msv_pkg::WIDX_JOBID, {$urandom, 32'd0} | {31'd0, valid, live_job_id});
	endtask

	task automatic random_traffic(input int count);
		int pick;
		int n = 0;
		while (n < count) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				random_job(1'b1);
				n += 10;
			end else if (pick < 14) begin
				// stray load, may clobber or invalidate the job
				load_word(4'($urandom), {$urandom, $urandom});
				n++;
			end else begin
				submit_share(($urandom_range(99) < 85) ? live_job_id : $urandom,
					$urandom, 1'($urandom_range(1)));
				n++;
			end
		end
	endtask

	initial begin
		live_job_id = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: no job, ignored index, valid bit with upper bits set, extremes
		submit_share(32'h0, 32'h0, 1'b0);
		load_word(4'd15, '1);
		load_word(4'd10, '1);
		load_word(msv_pkg::WIDX_JOBID, 64'hFFFF_FFFE_1234_5678);
		submit_share(32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
		for (int w = 0; w < 8; w++) load_word(4'(w), w[0] ? '1 : '0);
		load_word(msv_pkg::WIDX_VERSION, 64'hFFFF_FFFF_0000_0000);
		live_job_id = 32'hFFFF_FFFF;
		load_word(msv_pkg::WIDX_JOBID, 64'hFFFF_FFFF_FFFF_FFFF);
		push_item(OP_SUBMIT, 4'd0, '0, live_job_id, '1, '1, '0, 1'b0);
		push_item(OP_SUBMIT, 4'd0, '0, live_job_id, '0, '0, '1, 1'b1);
		push_item(OP_SUBMIT, 4'd0, '0, 32'h0, '0, '0, '0, 1'b0);
		push_item(OP_SUBMIT, 4'd0, '0, 32'hFFFF_FFFE, '1, '1, '1, 1'b1);
		random_traffic(220);
		drain_results();

		write_reg(REG_TARGET, '1);
		write_reg(REG_ANY, 64'h0);
		hold_request = 3000;
		random_traffic(240);
		drain_results();

		send_idle_pct = 58;
		recv_idle_pct = 31;
		write_reg(REG_TARGET, '0);
		random_traffic(240);
		drain_results();

		write_reg(REG_ANY, '1);
		random_traffic(240);
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_ANY, '0);
		write_reg(REG_TARGET, 64'h8000_0000_0000_0000);
		random_traffic(240);
		drain_results();

		if (fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

[files.f]
hdl/msv_pkg.sv
hdl/msv_queue.sv
hdl/msv_front.sv
hdl/msv_sha.sv
hdl/msv_back.sv
hdl/mining_share_validator_unit.sv
hdl/msv_checker.sv
sim/mining_share_validator_checker.sv
sim/mining_share_validator_unit_test.sv
